>>> rtl/alg_pkg.sv
// ============================================================================
// alg_pkg
// Shared types, constant tables and rounding helpers of the associated
// Legendre generator.
// ============================================================================
package alg_pkg;

    // Handshake status of a multi-cycle arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

    // Register indexes of the configuration port
    typedef enum logic [1:0] {
        CFG_TOP_DEGREE = 2'd0,
        CFG_KEEP_PHASE = 2'd1,
        CFG_NEG_ORDERS = 2'd2
    } cfg_index_t;

    localparam logic [2:0] TOP_DEGREE_RESET = 3'd3;

    // (2l-1)!! for l = 0..7
    localparam logic [17:0] DFACT [8] = '{
        18'd1, 18'd1, 18'd3, 18'd15, 18'd105, 18'd945, 18'd10395, 18'd135135
    };

    // n! for n = 0..14
    localparam logic [39:0] FACT [15] = '{
        40'd1, 40'd1, 40'd2, 40'd6, 40'd24, 40'd120, 40'd720, 40'd5040,
        40'd40320, 40'd362880, 40'd3628800, 40'd39916800, 40'd479001600,
        40'd6227020800, 40'd87178291200
    };

    // Saturate to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
        begin
            r = 32'sh7fffffff;
        end
        else if (v < -64'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Divide by 2^k, round to nearest, ties away from zero
    function automatic logic signed [63:0] round_shr(input logic signed [63:0] v,
                                                      input int k);
        logic [63:0] mag;
        logic [63:0] q;
        mag = v[63] ? (64'd0 - 64'(v)) : 64'(v);
        q   = (mag + (64'd1 << (k - 1))) >> k;
        return v[63] ? -$signed(q) : $signed(q);
    endfunction

endpackage

>>> rtl/alg_ram.sv
// ============================================================================
// alg_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ============================================================================
module alg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/alg_sqrt.sv
// ============================================================================
// alg_sqrt
// Iterative square root of a 31-bit value, two bits per cycle, rounded to
// nearest.
// ============================================================================
module alg_sqrt (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [30:0]         u,
    output alg_pkg::unit_status_t status,
    output logic [15:0]         root
);

    logic [30:0] u_reg;
    logic [31:0] r_reg;
    logic [30:0] bit_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [31:0] trial;

    assign trial = r_reg + 32'(bit_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            u_reg    <= '0;
            r_reg    <= '0;
            bit_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                u_reg    <= u;
                r_reg    <= '0;
                bit_reg  <= 31'd1 << 30;
                cnt_reg  <= 5'd16;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (32'(u_reg) >= trial)
                begin
                    u_reg <= u_reg - 31'(trial);
                    r_reg <= (r_reg >> 1) + 32'(bit_reg);
                end
                else
                begin
                    r_reg <= r_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // round up when the remainder exceeds the floor root
    assign root        = (32'(u_reg) > r_reg) ? 16'(r_reg + 32'd1) : r_reg[15:0];
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

>>> rtl/alg_div.sv
// ============================================================================
// alg_div
// Restoring divider, one quotient bit per cycle, rounding to nearest with
// ties away from zero. Divisor is positive.
// ============================================================================
module alg_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [63:0]   num,
    input  logic [63:0]          den,
    output alg_pkg::unit_status_t status,
    output logic signed [63:0]   quo
);

    logic [63:0] quo_reg;
    logic [64:0] rem_reg;
    logic [63:0] den_reg;
    logic        neg_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] mag;
    logic [64:0] rem_sh;
    logic        fits;

    assign mag    = num[63] ? (64'd0 - 64'(num)) : 64'(num);
    assign rem_sh = {rem_reg[63:0], quo_reg[63]};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            neg_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                quo_reg  <= mag + (den >> 1);
                rem_reg  <= '0;
                den_reg  <= den;
                neg_reg  <= num[63];
                cnt_reg  <= 7'd64;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? (rem_sh - {1'b0, den_reg}) : rem_sh;
                quo_reg <= {quo_reg[62:0], fits};
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quo         = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

>>> rtl/associated_legendre_generator_unit.sv
// ============================================================================
// associated_legendre_generator_unit
// Generates every associated Legendre value P(l,m)(x) up to the configured
// degree for one Q1.15 argument, in Q19.13 with saturation.
// ============================================================================
//
//  channel  | signals                          | direction | word
//  ---------+----------------------------------+-----------+-------------------
//  input    | in_valid, in_ready, x            | in        | one argument
//  output   | out_valid, out_ready, value,     | out       | one P(l,m) value
//           | degree, order, last              |           |
//  config   | cfg_we, cfg_index, cfg_wdata     | in        | register write
//
//  Sequence: one argument first runs the square root, then per degree the
//  diagonal terms, each order-recurrence term and each negative-order
//  term, the last two through the bit-serial divider; each output word
//  then takes a store read and a load.
//  Reset: asynchronous, active low; the value store is not cleared, every
//  entry is written before it is read.
//  Stalls: out_ready low holds the output register and the emit sequence;
//  in_ready is high only while idle, also while the last word still waits.
//
module associated_legendre_generator_unit #(
    parameter int DEGREE_CAP = 3
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] x,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] value,
    output logic [2:0]         degree,
    output logic signed [3:0]  order,
    output logic               last,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [2:0]         cfg_wdata
);

    localparam int DEPTH = (DEGREE_CAP + 1) * (DEGREE_CAP + 1);
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam logic [2:0] TopDeg = 3'(DEGREE_CAP);

    typedef enum logic [4:0] {
        S_IDLE, S_SQRT, S_L_START, S_T_UPD, S_DIAG_MUL, S_DIAG_WR,
        S_NEAR_MUL1, S_NEAR_MUL2, S_NEAR_WR,
        S_REC_RDA, S_REC_RDB, S_REC_M2, S_REC_M3, S_REC_DIV, S_REC_WAIT,
        S_NEG_RD, S_NEG_MUL, S_NEG_DIV, S_NEG_WAIT,
        S_NEXT_L, S_EMIT_RD, S_EMIT_LD
    } state_t;

    state_t state_reg;

    // configuration
    logic [2:0] deg_cfg_reg;
    logic       keep_phase_reg;
    logic       neg_orders_reg;

    // working registers
    logic signed [15:0] x_reg;
    logic [15:0]        s_reg;
    logic [30:0]        t_reg;
    logic [2:0]         top_reg;
    logic [2:0]         l_reg;
    logic signed [4:0]  m_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] num_reg;

    // output register
    logic               out_valid_reg;
    logic signed [31:0] value_reg;
    logic [2:0]         degree_reg;
    logic signed [3:0]  order_reg;
    logic               last_reg;

    // units
    alg_pkg::unit_status_t sqrt_st;
    alg_pkg::unit_status_t div_st;
    logic [15:0]           sqrt_root;
    logic                  sqrt_start;
    logic [30:0]           sqrt_u;
    logic signed [31:0]    x_sq;
    logic                  div_start;
    logic signed [63:0]    div_num;
    logic [63:0]           div_den;
    logic signed [63:0]    div_q;

    // store ports
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [31:0]       ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic signed [31:0] ram_rdata;

    // shared multiplier
    logic signed [48:0] mul_a;
    logic signed [18:0] mul_b;
    logic signed [67:0] mul_p;

    // misc combinational terms
    logic        in_acc;
    logic        slot_free;
    logic        emit_load;
    logic        emit_last;
    logic signed [63:0] diag_v;
    logic signed [63:0] neg_v;
    logic signed [31:0] emit_v;
    int          li;
    int          mi;

    function automatic logic [AW-1:0] idx_f(input int l, input int m);
        int i;
        i = l * l + l + m;
        return AW'(i);
    endfunction

    assign li = int'(l_reg);
    assign mi = int'(m_reg);

    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign emit_load = (state_reg == S_EMIT_LD) && slot_free;
    assign emit_last = (l_reg == top_reg) && (mi == li);

    // argument for the square root: 1 - x^2 in Q2.30
    assign x_sq       = x * x;
    assign sqrt_u     = 31'((32'sd1 <<< 30) - x_sq);
    assign sqrt_start = in_acc;

    alg_sqrt u_sqrt (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (sqrt_start),
        .u      (sqrt_u),
        .status (sqrt_st),
        .root   (sqrt_root)
    );

    // divider operands: order recurrence or negative-order factorial ratio
    always_comb
    begin
        div_start = 1'b0;
        div_num   = prod_reg;
        div_den   = 64'(alg_pkg::FACT[4'(li + mi)]);
        case (state_reg)
            S_REC_DIV:
            begin
                div_start = 1'b1;
                div_num   = num_reg - (prod_reg <<< 15);
                div_den   = 64'(li - mi) << 15;
            end
            S_NEG_DIV:
            begin
                div_start = 1'b1;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    alg_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (div_num),
        .den    (div_den),
        .status (div_st),
        .quo    (div_q)
    );

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = 49'(ram_rdata);
        mul_b = 19'(x_reg);
        case (state_reg)
            S_L_START:
            begin
                mul_a = 49'(t_reg);
                mul_b = 19'(s_reg);
            end
            S_DIAG_MUL:
            begin
                mul_a = 49'(t_reg);
                mul_b = 19'(alg_pkg::DFACT[l_reg]);
            end
            S_NEAR_MUL2, S_REC_M2:
            begin
                mul_a = prod_reg[48:0];
                mul_b = 19'(2 * li - 1);
            end
            S_REC_M3:
            begin
                mul_b = 19'(li - 1 + mi);
            end
            S_NEG_MUL:
            begin
                mul_b = 19'(alg_pkg::FACT[4'(li - mi)]);
            end
            default:
            begin
                mul_b = 19'(x_reg);
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // finished values: diagonal and negative-order ones before saturation, the emitted one saturated
    assign diag_v = l_reg[0] ? -alg_pkg::round_shr(prod_reg, 17)
                             : alg_pkg::round_shr(prod_reg, 17);
    assign neg_v  = m_reg[0] ? -div_q : div_q;
    assign emit_v = (!keep_phase_reg && m_reg[0])
                  ? alg_pkg::sat32(-64'(ram_rdata)) : ram_rdata;

    // store read and write selection
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_f(li, mi);
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = idx_f(li, mi);
        case (state_reg)
            S_DIAG_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_f(li, li);
                ram_wdata = alg_pkg::sat32(diag_v);
                ram_re    = (l_reg != 3'd0);
                ram_raddr = idx_f(li - 1, li - 1);
            end
            S_NEAR_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_f(li, li - 1);
                ram_wdata = alg_pkg::sat32(alg_pkg::round_shr(prod_reg, 15));
            end
            S_REC_RDA:
            begin
                ram_re    = 1'b1;
                ram_raddr = idx_f(li - 1, mi);
            end
            S_REC_RDB:
            begin
                ram_re    = 1'b1;
                ram_raddr = idx_f(li - 2, mi);
            end
            S_REC_WAIT:
            begin
                ram_we    = div_st.done;
                ram_wdata = alg_pkg::sat32(div_q);
            end
            S_NEG_RD, S_EMIT_RD:
            begin
                ram_re = 1'b1;
            end
            S_NEG_WAIT:
            begin
                ram_we    = div_st.done;
                ram_waddr = idx_f(li, -mi);
                ram_wdata = alg_pkg::sat32(neg_v);
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    alg_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sequencer: compute every value into the store, then stream it out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            deg_cfg_reg    <= alg_pkg::TOP_DEGREE_RESET;
            keep_phase_reg <= 1'b1;
            neg_orders_reg <= 1'b1;
            out_valid_reg  <= 1'b0;
            x_reg          <= '0;
            s_reg          <= '0;
            t_reg          <= '0;
            top_reg        <= '0;
            l_reg          <= '0;
            m_reg          <= '0;
            prod_reg       <= '0;
            num_reg        <= '0;
            value_reg      <= '0;
            degree_reg     <= '0;
            order_reg      <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            // configuration writes; unknown indexes drop
            if (cfg_we)
            begin
                case (cfg_index)
                    alg_pkg::CFG_TOP_DEGREE: deg_cfg_reg    <= cfg_wdata;
                    alg_pkg::CFG_KEEP_PHASE: keep_phase_reg <= cfg_wdata[0];
                    alg_pkg::CFG_NEG_ORDERS: neg_orders_reg <= cfg_wdata[0];
                    default:                 deg_cfg_reg    <= deg_cfg_reg;
                endcase
            end

            // drop the output word once taken, unless a new one loads
            if (out_valid_reg && out_ready && !emit_load)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        x_reg     <= x;
                        top_reg   <= (deg_cfg_reg > TopDeg) ? TopDeg
                                                            : deg_cfg_reg;
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    if (sqrt_st.done)
                    begin
                        s_reg     <= sqrt_root;
                        t_reg     <= 31'd1 << 30;
                        l_reg     <= '0;
                        state_reg <= S_L_START;
                    end
                end
                S_L_START:
                begin
                    prod_reg  <= mul_p[63:0];
                    state_reg <= (l_reg == 3'd0) ? S_DIAG_MUL : S_T_UPD;
                end
                S_T_UPD:
                begin
                    // advance the sectoral power with half-up rounding
                    t_reg     <= 31'((prod_reg + 64'sd16384) >>> 15);
                    state_reg <= S_DIAG_MUL;
                end
                S_DIAG_MUL:
                begin
                    prod_reg  <= mul_p[63:0];
                    state_reg <= S_DIAG_WR;
                end
                S_DIAG_WR:
                begin
                    state_reg <= (l_reg == 3'd0) ? S_NEXT_L : S_NEAR_MUL1;
                end
                S_NEAR_MUL1:
                begin
                    prod_reg  <= mul_p[63:0];
                    state_reg <= S_NEAR_MUL2;
                end
                S_NEAR_MUL2:
                begin
                    prod_reg  <= mul_p[63:0];
                    state_reg <= S_NEAR_WR;
                end
                S_NEAR_WR:
                begin
                    if (l_reg >= 3'd2)
                    begin
                        m_reg     <= 5'(li - 2);
                        state_reg <= S_REC_RDA;
                    end
                    else
                    begin
                        m_reg     <= 5'sd1;
                        state_reg <= S_NEG_RD;
                    end
                end
                S_REC_RDA:
                begin
                    state_reg <= S_REC_RDB;
                end
                S_REC_RDB:
                begin
                    prod_reg  <= mul_p[63:0];
                    state_reg <= S_REC_M2;
                end
                S_REC_M2:
                begin
                    prod_reg  <= mul_p[63:0];
                    state_reg <= S_REC_M3;
                end
                S_REC_M3:
                begin
                    num_reg   <= prod_reg;
                    prod_reg  <= mul_p[63:0];
                    state_reg <= S_REC_DIV;
                end
                S_REC_DIV:
                begin
                    state_reg <= S_REC_WAIT;
                end
                S_REC_WAIT:
                begin
                    if (div_st.done)
                    begin
                        if (m_reg == 5'sd0)
                        begin
                            m_reg     <= 5'sd1;
                            state_reg <= S_NEG_RD;
                        end
                        else
                        begin
                            m_reg     <= m_reg - 5'sd1;
                            state_reg <= S_REC_RDA;
                        end
                    end
                end
                S_NEG_RD:
                begin
                    state_reg <= S_NEG_MUL;
                end
                S_NEG_MUL:
                begin
                    prod_reg  <= mul_p[63:0];
                    state_reg <= S_NEG_DIV;
                end
                S_NEG_DIV:
                begin
                    state_reg <= S_NEG_WAIT;
                end
                S_NEG_WAIT:
                begin
                    if (div_st.done)
                    begin
                        if (mi == li)
                        begin
                            state_reg <= S_NEXT_L;
                        end
                        else
                        begin
                            m_reg     <= m_reg + 5'sd1;
                            state_reg <= S_NEG_RD;
                        end
                    end
                end
                S_NEXT_L:
                begin
                    if (l_reg == top_reg)
                    begin
                        l_reg     <= '0;
                        m_reg     <= '0;
                        state_reg <= S_EMIT_RD;
                    end
                    else
                    begin
                        l_reg     <= l_reg + 3'd1;
                        state_reg <= S_L_START;
                    end
                end
                S_EMIT_RD:
                begin
                    state_reg <= S_EMIT_LD;
                end
                S_EMIT_LD:
                begin
                    // hold the read word until the output register frees up
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        value_reg     <= emit_v;
                        degree_reg    <= l_reg;
                        order_reg     <= m_reg[3:0];
                        last_reg      <= emit_last;
                        if (emit_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            if (mi == li)
                            begin
                                l_reg <= l_reg + 3'd1;
                                m_reg <= neg_orders_reg
                                       ? -$signed({2'b00, l_reg + 3'd1}) : 5'sd0;
                            end
                            else
                            begin
                                m_reg <= m_reg + 5'sd1;
                            end
                            state_reg <= S_EMIT_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign degree    = degree_reg;
    assign order     = order_reg;
    assign last      = last_reg;

endmodule

>>> rtl/alg_checker.sv
// ============================================================================
// alg_checker
// Port-level checks of the associated Legendre generator.
// ============================================================================
module alg_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic signed [31:0] value,
    input logic [2:0]        degree,
    input logic signed [3:0] order,
    input logic              last
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value) && $stable(order))
        else $error("output word changed while stalled");

    // one argument at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again right after an accept");

    // the final word of a run is a sectoral value P(l,l)
    a_last_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> order == $signed({1'b0, degree}))
        else $error("last word is not P(l,l)");

    // while a run is still streaming, no new argument is taken
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready)
        else $error("input ready during a run");

endmodule

bind associated_legendre_generator_unit alg_checker u_alg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .degree    (degree),
    .order     (order),
    .last      (last)
);
